[rtl/core/endpoint_credit_flow_control_macros.svh]
// ----------------------------------------------------------------------------
// Endpoint credit flow control - assertion macros
// Shared concurrent assertion helpers; compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ENDPOINT_CREDIT_FLOW_CONTROL_MACROS_SVH
`define ENDPOINT_CREDIT_FLOW_CONTROL_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ECFC_ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication
`define ECFC_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ECFC_ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ECFC_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

[rtl/core/ecfc_pkg.sv]
// ----------------------------------------------------------------------------
// ecfc_pkg
// Types, codes and constants shared by the credit flow control block.
// ----------------------------------------------------------------------------
`default_nettype none

package ecfc_pkg;

  // parameter defaults
  localparam int ENDPOINTS_DEF    = 12;
  localparam int MAX_FRAME_DEF    = 4096;
  localparam int HEADER_BYTES_DEF = 8;
  localparam int MIN_TRAILER_DEF  = 2;

  // fixed field widths
  localparam int CREDIT_W   = 16;
  localparam int MASK_W     = 12;
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int TOTAL_W    = 17;   // payload + header bytes
  localparam int NUM_W      = 18;   // total + size - 1
  localparam int USED_W     = 17;
  localparam int DIV_CNT_W  = $clog2(NUM_W);
  localparam int S_TDATA_W  = 64;
  localparam int M_TDATA_W  = 64;

  // front/back queue
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;
  localparam int Q_CNT_W = 2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_CREDIT_BYTES = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FLOW_MASK    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_WEDGED       = 2'd2;

  typedef enum logic [1:0] {
    KIND_SEND  = 2'd0,
    KIND_GRANT = 2'd1,
    KIND_RX    = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_WEDGED      = 4'd1,
    ST_BAD_EP      = 4'd2,
    ST_NO_CREDITS  = 4'd3,
    ST_TOO_LONG    = 4'd4,
    ST_SHORT       = 4'd5,
    ST_BAD_TRAILER = 4'd6,
    ST_EMPTY       = 4'd7,
    ST_CONTROL     = 4'd8
  } status_t;

  // classified command, front to back
  typedef struct packed {
    kind_t                op;
    logic [7:0]           endpoint;
    status_t              status;    // everything but the credit check
    logic                 flow;
    logic [TOTAL_W-1:0]   total;
    logic [7:0]           grant;
    logic [15:0]          deliver;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/core/endpoint_credit_flow_control.sv]
// ----------------------------------------------------------------------------
// endpoint_credit_flow_control
// Per-endpoint transmit credit accounting and receive header checks.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one item per beat: s_tuser is the item kind (send, credit
//   grant, receive header), s_tdata the fields. Every item yields exactly
//   one result beat on m_*, in order.
//   cfg_we/cfg_addr/cfg_data write credit_bytes, flow_enable_mask and
//   device_wedged; write them only while no item is in flight.
//   Path: grants, receive headers, unused kinds and sends that fail before
//   the credit check go from the queue through the execute state to the
//   result register; a flow-controlled send first runs the bit-serial
//   ceil((payload + header) / credit_bytes) divide. The executor handles
//   one item at a time.
//   A two-entry command queue sits between classifier and executor, so up
//   to two more items are taken while one executes or a result waits.
//   Reset: credit counts and sequence counters clear to zero, credit_bytes
//   returns to 1, all twelve flow bits set, wedge cleared.
//   Receiver stall: the result register holds its beat; the executor stops,
//   the queue fills, then s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module endpoint_credit_flow_control #(
  parameter int ENDPOINTS    = ecfc_pkg::ENDPOINTS_DEF,
  parameter int MAX_FRAME    = ecfc_pkg::MAX_FRAME_DEF,
  parameter int HEADER_BYTES = ecfc_pkg::HEADER_BYTES_DEF,
  parameter int MIN_TRAILER  = ecfc_pkg::MIN_TRAILER_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input items
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // endpoint[7:0], payload_length[23:8], grant_credits[31:24],
  // trailer_flag[32], trailer_length[40:33], received_length[56:41], zero
  input  logic [ecfc_pkg::S_TDATA_W-1:0]      s_tdata,
  // kind[1:0]
  input  logic [1:0]                          s_tuser,
  // results
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // status[3:0], sequence_number[11:4], credits_used[28:12],
  // credits_left[44:29], deliver_length[60:45], zero
  output logic [ecfc_pkg::M_TDATA_W-1:0]      m_tdata,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [ecfc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ecfc_pkg::CFG_W-1:0]          cfg_data
);

  logic [ecfc_pkg::CREDIT_W-1:0]  credit_bytes;
  logic [ecfc_pkg::MASK_W-1:0]    flow_enable_mask;
  logic                           device_wedged;

  logic                           push;
  logic                           q_full;
  logic                           q_valid;
  logic                           q_pop;
  ecfc_pkg::cmd_t                 front_cmd;
  ecfc_pkg::cmd_t                 q_cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      credit_bytes     <= 16'd1;
      flow_enable_mask <= '1;
      device_wedged    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ecfc_pkg::CFG_CREDIT_BYTES: credit_bytes     <= cfg_data;
        ecfc_pkg::CFG_FLOW_MASK:    flow_enable_mask <= cfg_data[ecfc_pkg::MASK_W-1:0];
        ecfc_pkg::CFG_WEDGED:       device_wedged    <= cfg_data[0];
        default: ;  // unused index, ignored
      endcase
    end
  end

  // classify: all stateless checks
  ecfc_front #(
    .ENDPOINTS    (ENDPOINTS),
    .MAX_FRAME    (MAX_FRAME),
    .HEADER_BYTES (HEADER_BYTES),
    .MIN_TRAILER  (MIN_TRAILER)
  ) u_front (
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tuser          (s_tuser),
    .flow_enable_mask (flow_enable_mask),
    .device_wedged    (device_wedged),
    .push             (push),
    .cmd              (front_cmd),
    .q_full           (q_full)
  );

  // command queue
  ecfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_cmd    (front_cmd),
    .full      (q_full),
    .out_valid (q_valid),
    .pop       (q_pop),
    .out_cmd   (q_cmd)
  );

  // execute: divide, credit and sequence update, result register
  ecfc_back #(
    .ENDPOINTS (ENDPOINTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .credit_bytes (credit_bytes),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata)
  );

endmodule

`default_nettype wire

[rtl/core/ecfc_front.sv]
// ----------------------------------------------------------------------------
// ecfc_front
// Unpacks an input beat and runs every check that needs no endpoint state.
// ----------------------------------------------------------------------------
`default_nettype none

module ecfc_front #(
  parameter int ENDPOINTS    = ecfc_pkg::ENDPOINTS_DEF,
  parameter int MAX_FRAME    = ecfc_pkg::MAX_FRAME_DEF,
  parameter int HEADER_BYTES = ecfc_pkg::HEADER_BYTES_DEF,
  parameter int MIN_TRAILER  = ecfc_pkg::MIN_TRAILER_DEF
) (
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ecfc_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic [1:0]                        s_tuser,
  input  logic [ecfc_pkg::MASK_W-1:0]       flow_enable_mask,
  input  logic                              device_wedged,
  output logic                              push,
  output ecfc_pkg::cmd_t                    cmd,
  input  logic                              q_full
);

  logic [7:0]                    endpoint;
  logic [15:0]                   plen;
  logic [7:0]                    grant;
  logic                          tflag;
  logic [7:0]                    tlen;
  logic [15:0]                   rlen;
  logic [7:0]                    trailer;
  logic [15:0]                   remain;
  logic [ecfc_pkg::TOTAL_W-1:0]  total;
  logic                          ep_ok;
  logic                          flow;

  assign endpoint = s_tdata[7:0];
  assign plen     = s_tdata[23:8];
  assign grant    = s_tdata[31:24];
  assign tflag    = s_tdata[32];
  assign tlen     = s_tdata[40:33];
  assign rlen     = s_tdata[56:41];

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  assign total   = {1'b0, plen} + ecfc_pkg::TOTAL_W'(HEADER_BYTES);
  assign ep_ok   = endpoint < 8'(ENDPOINTS);
  // no mask bit above the mask width: flow control off there
  assign flow    = (endpoint < 8'(ecfc_pkg::MASK_W)) && flow_enable_mask[endpoint[3:0]];
  assign trailer = tflag ? tlen : 8'd0;
  assign remain  = plen - {8'd0, trailer};

  always_comb begin
    cmd          = '0;
    cmd.op       = ecfc_pkg::kind_t'(s_tuser);
    cmd.endpoint = endpoint;
    cmd.flow     = flow;
    cmd.total    = total;
    cmd.grant    = grant;
    cmd.status   = ecfc_pkg::ST_OK;
    unique case (ecfc_pkg::kind_t'(s_tuser))
      ecfc_pkg::KIND_SEND: begin
        if (device_wedged)  cmd.status = ecfc_pkg::ST_WEDGED;
        else if (!ep_ok)    cmd.status = ecfc_pkg::ST_BAD_EP;
      end
      ecfc_pkg::KIND_GRANT: begin
        if (!ep_ok) cmd.status = ecfc_pkg::ST_BAD_EP;
      end
      ecfc_pkg::KIND_RX: begin
        if (!ep_ok) begin
          cmd.status = ecfc_pkg::ST_BAD_EP;
        end else if (total > ecfc_pkg::TOTAL_W'(MAX_FRAME)) begin
          cmd.status = ecfc_pkg::ST_TOO_LONG;
        end else if (rlen < plen) begin
          cmd.status = ecfc_pkg::ST_SHORT;
        end else if (tflag && (tlen < 8'(MIN_TRAILER) || {8'd0, tlen} > plen)) begin
          cmd.status = ecfc_pkg::ST_BAD_TRAILER;
        end else if (remain == 16'd0) begin
          cmd.status = ecfc_pkg::ST_EMPTY;
        end else begin
          cmd.deliver = remain;
          cmd.status  = (endpoint == 8'd0) ? ecfc_pkg::ST_CONTROL : ecfc_pkg::ST_OK;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/ecfc_queue.sv]
// ----------------------------------------------------------------------------
// ecfc_queue
// Short command FIFO decoupling the classifier from the executor.
// ----------------------------------------------------------------------------
`default_nettype none
`include "endpoint_credit_flow_control_macros.svh"

module ecfc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ecfc_pkg::cmd_t  in_cmd,
  output logic            full,
  output logic            out_valid,
  input  logic            pop,
  output ecfc_pkg::cmd_t  out_cmd
);

  ecfc_pkg::cmd_t                 entries [ecfc_pkg::Q_DEPTH];
  logic [ecfc_pkg::Q_AW-1:0]      wr_ptr;
  logic [ecfc_pkg::Q_AW-1:0]      rd_ptr;
  logic [ecfc_pkg::Q_CNT_W-1:0]   count;
  logic                           do_pop;

  assign full      = count == ecfc_pkg::Q_CNT_W'(ecfc_pkg::Q_DEPTH);
  assign out_valid = count != '0;
  assign out_cmd   = entries[rd_ptr];
  assign do_pop    = pop && out_valid;

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= in_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)   wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !push) count <= count - 1'b1;
    end
  end

  `ECFC_ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, count <= ecfc_pkg::Q_CNT_W'(ecfc_pkg::Q_DEPTH))
  `ECFC_ASSERT_NEXT(a_pop_drains, clk, rst, do_pop && !push, count == $past(count) - 1'b1)
  `ECFC_ASSERT_IMPLIES(a_no_push_full, clk, rst, full, !push)

endmodule

`default_nettype wire

[rtl/core/ecfc_back.sv]
// ----------------------------------------------------------------------------
// ecfc_back
// Executes commands: credit divide, credit and sequence update, result beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "endpoint_credit_flow_control_macros.svh"

module ecfc_back #(
  parameter int ENDPOINTS = ecfc_pkg::ENDPOINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  ecfc_pkg::cmd_t                    q_cmd,
  output logic                              q_pop,
  input  logic [ecfc_pkg::CREDIT_W-1:0]     credit_bytes,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ecfc_pkg::M_TDATA_W-1:0]    m_tdata
);

  localparam int EP_W = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t                               state;
  ecfc_pkg::cmd_t                       cur;
  logic [15:0]                          credit_counts     [ENDPOINTS];
  logic [7:0]                           sequence_counters [ENDPOINTS];

  // divider
  logic [ecfc_pkg::NUM_W-1:0]           quot;
  logic [15:0]                          rem;
  logic [ecfc_pkg::DIV_CNT_W-1:0]       div_cnt;
  logic [15:0]                          size_eff;
  logic [16:0]                          shifted;
  logic [17:0]                          diff;
  logic                                 ge;
  logic [ecfc_pkg::NUM_W-1:0]           numer;
  logic                                 need_div;

  // execute
  logic [EP_W-1:0]                      ep_idx;
  logic [15:0]                          cred;
  logic [7:0]                           seqv;
  logic                                 out_free;
  logic                                 fire;
  logic                                 cred_we;
  logic [15:0]                          cred_wdata;
  logic                                 seq_we;
  logic [16:0]                          sum;
  ecfc_pkg::status_t                    res_status;
  logic [7:0]                           res_seq;
  logic [ecfc_pkg::USED_W-1:0]          res_used;
  logic [15:0]                          res_left;
  logic [15:0]                          res_deliver;

  // result register
  ecfc_pkg::status_t                    out_status;
  logic [7:0]                           out_seq;
  logic [ecfc_pkg::USED_W-1:0]          out_used;
  logic [15:0]                          out_left;
  logic [15:0]                          out_deliver;

  assign size_eff = (credit_bytes == '0) ? 16'd1 : credit_bytes;
  assign shifted  = {rem, quot[ecfc_pkg::NUM_W-1]};
  assign diff     = {1'b0, shifted} - {2'b00, size_eff};
  assign ge       = !diff[17];
  assign numer    = {1'b0, q_cmd.total} + ecfc_pkg::NUM_W'(size_eff) - 1'b1;
  assign need_div = q_cmd.op == ecfc_pkg::KIND_SEND && q_cmd.status == ecfc_pkg::ST_OK
                    && q_cmd.flow;

  assign q_pop    = state == S_IDLE;
  assign ep_idx   = cur.endpoint[EP_W-1:0];
  assign cred     = credit_counts[ep_idx];
  assign seqv     = sequence_counters[ep_idx];
  assign out_free = !m_tvalid || m_tready;
  assign fire     = state == S_EXEC && out_free;

  always_comb begin
    res_status  = cur.status;
    res_seq     = '0;
    res_used    = '0;
    res_left    = '0;
    res_deliver = '0;
    cred_we     = 1'b0;
    cred_wdata  = cred;
    seq_we      = 1'b0;
    sum         = {1'b0, cred} + {9'd0, cur.grant};
    case (cur.op)
      ecfc_pkg::KIND_SEND: begin
        if (cur.status == ecfc_pkg::ST_OK) begin
          if (cur.flow) res_used = quot[ecfc_pkg::USED_W-1:0];
          if (cur.flow && {1'b0, cred} < res_used) begin
            res_status = ecfc_pkg::ST_NO_CREDITS;
            res_left   = cred;
          end else begin
            cred_wdata = cred - res_used[15:0];
            cred_we    = cur.flow;
            res_seq    = seqv;
            seq_we     = 1'b1;
            res_left   = cred_wdata;
          end
        end
      end
      ecfc_pkg::KIND_GRANT: begin
        if (cur.status == ecfc_pkg::ST_OK) begin
          cred_wdata = sum[16] ? 16'hFFFF : sum[15:0];
          cred_we    = 1'b1;
          res_left   = cred_wdata;
        end
      end
      ecfc_pkg::KIND_RX: begin
        if (cur.status != ecfc_pkg::ST_BAD_EP) begin
          res_left    = cred;
          res_deliver = cur.deliver;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (q_valid) state <= need_div ? S_DIV : S_EXEC;
        S_DIV:  if (div_cnt == ecfc_pkg::DIV_CNT_W'(ecfc_pkg::NUM_W - 1)) state <= S_EXEC;
        S_EXEC: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      cur     <= q_cmd;
      quot    <= numer;
      rem     <= '0;
      div_cnt <= '0;
    end else if (state == S_DIV) begin
      rem     <= ge ? diff[15:0] : shifted[15:0];
      quot    <= {quot[ecfc_pkg::NUM_W-2:0], ge};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENDPOINTS; i++) begin
        credit_counts[i]     <= '0;
        sequence_counters[i] <= '0;
      end
    end else if (fire) begin
      if (cred_we) credit_counts[ep_idx]     <= cred_wdata;
      if (seq_we)  sequence_counters[ep_idx] <= seqv + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status  <= res_status;
      out_seq     <= res_seq;
      out_used    <= res_used;
      out_left    <= res_left;
      out_deliver <= res_deliver;
    end
  end

  assign m_tdata = {3'd0, out_deliver, out_left, out_used, out_seq, out_status};

  `ECFC_ASSERT_NEXT(a_exec_loads, clk, rst, fire, m_tvalid)
  `ECFC_ASSERT_IMPLIES(a_rem_bound, clk, rst, state == S_DIV, rem < size_eff)
  `ECFC_ASSERT_IMPLIES(a_seq_only_ok, clk, rst, m_tvalid && out_status != ecfc_pkg::ST_OK, out_seq == 8'd0)

endmodule

`default_nettype wire
